### rtl/sfr_pkg.sv
package sfr_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_BYTES      = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH     = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_BYTES  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_LENGTH = 4'd3;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT_TEXT,
        ST_EMIT_REPL
    } sfr_state_t;

endpackage

### rtl/streaming_find_replace.sv
// Byte-stream find and replace. Each transaction on the input channel carries one text
// byte; the block answers with zero to eight output transactions, the last one flagged by
// last_of_run. Bytes that may still begin an occurrence of the pattern are held back and
// released once a later byte decides them. A shared lane comparator checks the held bytes
// against the pattern at one head offset per cycle. An ordinary byte is accepted, then
// searched from head offset zero upward (one to nine offsets), and its output bytes are
// taken one per cycle while out_ready is high; a newline skips the search. in_ready is
// high only while no item is in work. Configuration writes are always taken and must only
// be issued while the block is idle.
module streaming_find_replace #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        in_byte,
    input  logic                              end_of_stream,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        out_byte,
    output logic                              last_of_run
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [3:0] raw);
        logic [LEN_W-1:0] res;
        if (raw == 4'd0)
        begin
            res = LEN_W'(1);
        end
        else if (32'(raw) > MAX_PATTERN)
        begin
            res = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            res = LEN_W'(raw);
        end
        return res;
    endfunction

    sfr_pkg::sfr_state_t state_reg, state_next;

    logic [sfr_pkg::CFG_DATA_W-1:0] pattern_reg;
    logic [sfr_pkg::CFG_DATA_W-1:0] repl_reg;
    logic [3:0]                     plen_raw_reg;
    logic [3:0]                     rlen_raw_reg;

    logic [7:0]       buf_reg  [MAX_PATTERN];
    logic [7:0]       buf_next [MAX_PATTERN];
    logic [LEN_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0] fill_reg, fill_next;
    logic [LEN_W-1:0] head_reg, head_next;
    logic [LEN_W-1:0] ptr_reg, ptr_next;
    logic [LEN_W-1:0] total_reg, total_next;
    logic             eos_reg, eos_next;

    logic [7:0]       aligned [MAX_PATTERN];
    logic             match;
    logic [LEN_W-1:0] plen;
    logic [LEN_W-1:0] rlen;
    logic [LEN_W-1:0] span;
    logic [LEN_W-1:0] release_cnt;
    logic [LEN_W-1:0] keep_cnt;
    logic [LEN_W-1:0] emit_limit;
    logic             rep_hit;
    logic             keep_hit;
    logic             emit_last;
    logic             newline_in;

    sfr_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W),
        .IDX_W       (IDX_W)
    ) u_match (
        .buffer  (buf_reg),
        .head    (head_reg),
        .fill    (fill_reg),
        .pattern (pattern_reg),
        .aligned (aligned),
        .match   (match)
    );

    assign plen        = clamp_len(plen_raw_reg);
    assign rlen        = clamp_len(rlen_raw_reg);
    assign span        = fill_reg - head_reg;
    assign rep_hit     = (head_reg == '0) && (fill_reg == plen) && match;
    assign keep_hit    = (span < plen) && match;
    assign release_cnt = eos_reg ? fill_reg : head_reg;
    assign keep_cnt    = eos_reg ? '0 : span;
    assign newline_in  = (in_byte == sfr_pkg::NEWLINE_BYTE);
    assign emit_limit  = (state_reg == sfr_pkg::ST_EMIT_REPL) ? rlen : total_reg;
    assign emit_last   = (ptr_reg == emit_limit - LEN_W'(1));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg  <= '0;
            plen_raw_reg <= 4'd1;
            repl_reg     <= '0;
            rlen_raw_reg <= 4'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sfr_pkg::CFG_PATTERN_BYTES:      pattern_reg  <= cfg_data;
                sfr_pkg::CFG_PATTERN_LENGTH:     plen_raw_reg <= cfg_data[3:0];
                sfr_pkg::CFG_REPLACEMENT_BYTES:  repl_reg     <= cfg_data;
                sfr_pkg::CFG_REPLACEMENT_LENGTH: rlen_raw_reg <= cfg_data[3:0];
                default:                         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfr_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg   <= buf_next;
        fill_reg  <= fill_next;
        head_reg  <= head_next;
        ptr_reg   <= ptr_next;
        total_reg <= total_next;
        eos_reg   <= eos_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            sfr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = newline_in ? sfr_pkg::ST_EMIT_TEXT : sfr_pkg::ST_SEARCH;
                end
            end
            sfr_pkg::ST_SEARCH:
            begin
                if (rep_hit)
                begin
                    state_next = sfr_pkg::ST_EMIT_REPL;
                end
                else if (keep_hit)
                begin
                    state_next = (release_cnt == '0) ? sfr_pkg::ST_IDLE
                                                     : sfr_pkg::ST_EMIT_TEXT;
                end
            end
            sfr_pkg::ST_EMIT_TEXT, sfr_pkg::ST_EMIT_REPL:
            begin
                if (out_ready && emit_last)
                begin
                    state_next = sfr_pkg::ST_IDLE;
                end
            end
            default: state_next = sfr_pkg::ST_IDLE;
        endcase
    end

    // Handshake and output drive
    always_comb
    begin
        cfg_ready   = 1'b1;
        in_ready    = (state_reg == sfr_pkg::ST_IDLE);
        out_valid   = (state_reg == sfr_pkg::ST_EMIT_TEXT) ||
                      (state_reg == sfr_pkg::ST_EMIT_REPL);
        last_of_run = emit_last;
        if (state_reg == sfr_pkg::ST_EMIT_REPL)
        begin
            out_byte = repl_reg[{ptr_reg[IDX_W-1:0], 3'b000} +: 8];
        end
        else
        begin
            out_byte = buf_reg[ptr_reg[IDX_W-1:0]];
        end
    end

    // Datapath
    always_comb
    begin
        buf_next   = buf_reg;
        count_next = count_reg;
        fill_next  = fill_reg;
        head_next  = head_reg;
        ptr_next   = ptr_reg;
        total_next = total_reg;
        eos_next   = eos_reg;
        unique case (state_reg)
            sfr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    buf_next[count_reg[IDX_W-1:0]] = in_byte;
                    fill_next = count_reg + LEN_W'(1);
                    eos_next  = end_of_stream;
                    ptr_next  = '0;
                    if (newline_in)
                    begin
                        // release everything, newline included, keep nothing
                        head_next  = count_reg + LEN_W'(1);
                        total_next = count_reg + LEN_W'(1);
                    end
                    else
                    begin
                        head_next = '0;
                    end
                end
            end
            sfr_pkg::ST_SEARCH:
            begin
                if (!rep_hit)
                begin
                    if (keep_hit)
                    begin
                        total_next = release_cnt;
                        if (release_cnt == '0)
                        begin
                            buf_next   = aligned;
                            count_next = keep_cnt;
                        end
                    end
                    else
                    begin
                        head_next = head_reg + LEN_W'(1);
                    end
                end
            end
            sfr_pkg::ST_EMIT_TEXT:
            begin
                if (out_ready)
                begin
                    ptr_next = ptr_reg + LEN_W'(1);
                    if (emit_last)
                    begin
                        // compact the survivors down to the front of the buffer
                        buf_next   = aligned;
                        count_next = keep_cnt;
                    end
                end
            end
            sfr_pkg::ST_EMIT_REPL:
            begin
                if (out_ready)
                begin
                    ptr_next = ptr_reg + LEN_W'(1);
                    if (emit_last)
                    begin
                        count_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

### rtl/sfr_match.sv
module sfr_match #(
    parameter int MAX_PATTERN = 8,
    parameter int LEN_W       = $clog2(MAX_PATTERN + 1),
    parameter int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
    input  logic [7:0]                    buffer [MAX_PATTERN],
    input  logic [LEN_W-1:0]              head,
    input  logic [LEN_W-1:0]              fill,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] pattern,
    output logic [7:0]                    aligned [MAX_PATTERN],
    output logic                          match
);

    logic [LEN_W-1:0] span;
    logic [LEN_W:0]   pos;

    assign span = fill - head;

    // Compare the buffer, viewed from the head, against the pattern on every lane below fill - head at once.
    always_comb
    begin
        match = 1'b1;
        pos   = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            pos = {1'b0, head} + (LEN_W + 1)'(i);
            if (pos < (LEN_W + 1)'(MAX_PATTERN))
            begin
                aligned[i] = buffer[pos[IDX_W-1:0]];
            end
            else
            begin
                aligned[i] = '0;
            end
            if ((LEN_W'(i) < span) && (aligned[i] != pattern[8*i +: 8]))
            begin
                match = 1'b0;
            end
        end
    end

endmodule

### verif/streaming_find_replace_tb.sv
module streaming_find_replace_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 24;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int STALL_CYCLES    = 300;
    localparam int STALL_AFTER     = 60;
    localparam int USE_PREDICTION  = -1;
    localparam int INDEX_W         = sfr_pkg::CFG_INDEX_W;
    localparam int DATA_W          = sfr_pkg::CFG_DATA_W;

    localparam logic [INDEX_W-1:0] CFG_SPARE_INDEX = 4'd9;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } text_out_t;

    typedef struct {
        bit                    is_reg;
        logic [INDEX_W-1:0]    idx;
        logic [DATA_W-1:0]     data;
        logic [7:0]            b;
        logic                  eos;
        int                    typed_n;
        logic [63:0]           typed;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [INDEX_W-1:0]     cfg_index = '0;
    logic [DATA_W-1:0]      cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [7:0]             in_byte = '0;
    logic                   end_of_stream = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [7:0]             out_byte;
    logic                   last_of_run;

    // register copies and held bytes of the rewriter
    logic [63:0] pat_word = '0;
    logic [3:0]  pat_len_reg = 4'd1;
    logic [63:0] repl_word = '0;
    logic [3:0]  repl_len_reg = 4'd1;
    logic [63:0] held_word = '0;
    int          held_n = 0;

    text_out_t rewritten_q[$];
    text_out_t due;
    int        failures = 0;
    int        results_taken = 0;
    int        cycle_count = 0;
    bit        no_gaps = 1'b0;
    bit        text_sent = 1'b0;

    streaming_find_replace dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("streaming_find_replace_tb NOT OK");
            $finish;
        end
    end

    function automatic int eff_len(input logic [3:0] v);
        if (v < 4'd1)
            return 1;
        if (v > 4'd8)
            return 8;
        return int'(v);
    endfunction

    function automatic bit is_prefix(input logic [63:0] w, input int start, input int len);
        int i;
        for (i = 0; i < len; i++)
            if (w[8*(start+i) +: 8] != pat_word[8*i +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    // Rewrite one input byte against the current registers and held bytes.
    function automatic void rewrite_byte(input logic [7:0] b, input logic eos,
                                         output text_out_t res[8], output int n_res);
        logic [63:0] work;
        int          n;
        int          s;
        int          i;
        int          plen;
        int          rlen;
        n_res = 0;
        plen  = eff_len(pat_len_reg);
        rlen  = eff_len(repl_len_reg);
        if (b == sfr_pkg::NEWLINE_BYTE)
        begin
            for (i = 0; i < held_n; i++)
            begin
                res[n_res] = '{held_word[8*i +: 8], 1'b0};
                n_res++;
            end
            held_n = 0;
            res[n_res] = '{b, 1'b0};
            n_res++;
        end
        else
        begin
            work = held_word;
            work[8*held_n +: 8] = b;
            n = held_n + 1;
            if (n == plen && is_prefix(work, 0, n))
            begin
                for (i = 0; i < rlen; i++)
                begin
                    res[n_res] = '{repl_word[8*i +: 8], 1'b0};
                    n_res++;
                end
                held_n = 0;
            end
            else
            begin
                // release the fewest leading bytes so the rest is a proper prefix
                for (s = 0; s < n; s++)
                    if (n - s < plen && is_prefix(work, s, n - s))
                        break;
                for (i = 0; i < s; i++)
                begin
                    res[n_res] = '{work[8*i +: 8], 1'b0};
                    n_res++;
                end
                held_n = 0;
                for (i = s; i < n; i++)
                begin
                    held_word[8*held_n +: 8] = work[8*i +: 8];
                    held_n++;
                end
            end
            if (eos)
            begin
                for (i = 0; i < held_n; i++)
                begin
                    res[n_res] = '{held_word[8*i +: 8], 1'b0};
                    n_res++;
                end
                held_n = 0;
            end
        end
        if (n_res > 0)
            res[n_res-1].last = 1'b1;
    endfunction

    function automatic stim_row_t reg_row(input logic [INDEX_W-1:0] idx,
                                          input logic [DATA_W-1:0] data);
        stim_row_t r;
        r = '{1'b1, idx, data, 8'h00, 1'b0, USE_PREDICTION, 64'h0};
        return r;
    endfunction

    function automatic stim_row_t text_row(input logic [7:0] b, input logic eos);
        stim_row_t r;
        r = '{1'b0, '0, '0, b, eos, USE_PREDICTION, 64'h0};
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic [7:0] b, input logic eos,
                                            input int n, input logic [63:0] bytes);
        stim_row_t r;
        r = '{1'b0, '0, '0, b, eos, n, bytes};
        return r;
    endfunction

    function automatic logic maybe_end();
        return logic'($urandom_range(0, 24) == 0);
    endfunction

    // byte likely to extend or restart a partial match
    function automatic logic [7:0] near_byte(input int plen);
        int k;
        k = $urandom_range(0, plen - 1);
        if ($urandom_range(0, 9) < 7)
            return pat_word[8*k +: 8];
        return 8'h61 + 8'($urandom_range(0, 3));
    endfunction

    task automatic write_reg(input logic [INDEX_W-1:0] idx,
                             input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            sfr_pkg::CFG_PATTERN_BYTES:      pat_word     = data;
            sfr_pkg::CFG_PATTERN_LENGTH:     pat_len_reg  = data[3:0];
            sfr_pkg::CFG_REPLACEMENT_BYTES:  repl_word    = data;
            sfr_pkg::CFG_REPLACEMENT_LENGTH: repl_len_reg = data[3:0];
            default: ;
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eos,
                             input int typed_n, input logic [63:0] typed);
        text_out_t res[8];
        int        n_res;
        int        gap;
        int        i;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        cfg_valid <= 1'b0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_byte       <= b;
        end_of_stream <= eos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        rewrite_byte(b, eos, res, n_res);
        if (typed_n == USE_PREDICTION)
        begin
            for (i = 0; i < n_res; i++)
                rewritten_q.push_back(res[i]);
        end
        else
        begin
            for (i = 0; i < typed_n; i++)
                rewritten_q.push_back('{typed[8*i +: 8], logic'(i == typed_n - 1)});
        end
        text_sent = 1'b1;
    endtask

    // drop valid, wait for every expected byte, then let a trailing search finish
    task automatic settle();
        in_valid <= 1'b0;
        while (rewritten_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        text_sent = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_taken = results_taken + 1;
            if (rewritten_q.size() == 0)
            begin
                $error("out_byte: no transaction expected, got %02h", out_byte);
                failures++;
            end
            else
            begin
                due = rewritten_q.pop_front();
                if (out_byte !== due.b)
                begin
                    $error("out_byte: expected %02h, got %02h", due.b, out_byte);
                    failures++;
                end
                if (last_of_run !== due.last)
                begin
                    $error("last_of_run: expected %0b, got %0b", due.last, last_of_run);
                    failures++;
                end
            end
        end
    end

    initial
    begin : result_sink
        int gap;
        bit stalled;
        stalled = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            // hold off once for a long stretch so the block backs up into its input
            if (!stalled && results_taken >= STALL_AFTER)
            begin
                stalled = 1'b1;
                out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        stim_row_t      rows[$];
        logic [63:0]    word;
        logic [63:0]    len_data;
        logic [3:0]     len_nib;
        logic [7:0]     b;
        int             ph;
        int             mode;
        int             sent;
        int             plen;
        int             pick;
        int             spoil;
        int             cut;
        int             i;

        // reset registers: pattern 00 of one byte, replaced by 00
        rows.push_back(typed_row(8'h00, 1'b0, 1, 64'h00));
        rows.push_back(typed_row(8'hFF, 1'b0, 1, 64'hFF));
        rows.push_back(typed_row(sfr_pkg::NEWLINE_BYTE, 1'b0, 1,
                                 {56'h0, sfr_pkg::NEWLINE_BYTE}));
        rows.push_back(typed_row(8'h41, 1'b1, 1, 64'h41));
        // "abc" -> eight-byte replacement
        rows.push_back(reg_row(sfr_pkg::CFG_PATTERN_BYTES, 64'h636261));
        rows.push_back(reg_row(sfr_pkg::CFG_PATTERN_LENGTH, 64'd3));
        rows.push_back(reg_row(sfr_pkg::CFG_REPLACEMENT_BYTES, 64'h0123456789ABCDEF));
        rows.push_back(reg_row(sfr_pkg::CFG_REPLACEMENT_LENGTH, 64'd8));
        rows.push_back(typed_row(8'h61, 1'b0, 0, 64'h0));
        rows.push_back(typed_row(8'h62, 1'b0, 0, 64'h0));
        rows.push_back(typed_row(8'h63, 1'b0, 8, 64'h0123456789ABCDEF));
        rows.push_back(text_row(8'h61, 1'b0));
        rows.push_back(text_row(8'h62, 1'b0));
        rows.push_back(text_row(8'hFF, 1'b0));
        rows.push_back(text_row(8'h61, 1'b0));
        rows.push_back(text_row(sfr_pkg::NEWLINE_BYTE, 1'b0));
        // leave "ab" held, then shrink the pattern below the held bytes (length 0 acts as 1)
        rows.push_back(text_row(8'h61, 1'b0));
        rows.push_back(text_row(8'h62, 1'b0));
        rows.push_back(reg_row(sfr_pkg::CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0));
        rows.push_back(text_row(8'h61, 1'b0));
        // newline inside the pattern can never be matched
        rows.push_back(reg_row(sfr_pkg::CFG_PATTERN_BYTES,
                               {48'h0, sfr_pkg::NEWLINE_BYTE, 8'h61}));
        rows.push_back(reg_row(sfr_pkg::CFG_PATTERN_LENGTH, 64'd2));
        rows.push_back(text_row(8'h61, 1'b0));
        rows.push_back(text_row(sfr_pkg::NEWLINE_BYTE, 1'b1));
        // eight-byte pattern (length 15 acts as 8), one-byte replacement, spare index ignored
        rows.push_back(reg_row(sfr_pkg::CFG_PATTERN_BYTES, 64'h6161616161616161));
        rows.push_back(reg_row(sfr_pkg::CFG_PATTERN_LENGTH, 64'hF));
        rows.push_back(reg_row(sfr_pkg::CFG_REPLACEMENT_BYTES, 64'h0));
        rows.push_back(reg_row(sfr_pkg::CFG_REPLACEMENT_LENGTH, 64'h0));
        rows.push_back(reg_row(CFG_SPARE_INDEX, '1));
        for (i = 0; i < 7; i++)
            rows.push_back(text_row(8'h61, 1'b0));
        rows.push_back(typed_row(8'hFF, 1'b1, 8, 64'hFF61616161616161));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[r])
        begin
            if (rows[r].is_reg)
            begin
                if (text_sent)
                    settle();
                write_reg(rows[r].idx, rows[r].data);
            end
            else
            begin
                send_byte(rows[r].b, rows[r].eos, rows[r].typed_n, rows[r].typed);
            end
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            settle();
            no_gaps = (ph % 3 == 2);
            mode = $urandom_range(0, 2);
            for (i = 0; i < 8; i++)
            begin
                case (mode)
                    0:       word[8*i +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
                    1:       word[8*i +: 8] = ($urandom_range(0, 7) == 0)
                                              ? sfr_pkg::NEWLINE_BYTE
                                              : 8'h61 + 8'($urandom_range(0, 3));
                    default: word[8*i +: 8] = 8'($urandom_range(0, 255));
                endcase
            end
            write_reg(sfr_pkg::CFG_PATTERN_BYTES, word);
            case (ph)
                0:       len_nib = 4'd1;
                1:       len_nib = 4'd8;
                2:       len_nib = 4'd0;
                3:       len_nib = 4'd15;
                default: len_nib = 4'($urandom_range(1, 8));
            endcase
            len_data = {$urandom, $urandom};
            len_data[3:0] = len_nib;
            write_reg(sfr_pkg::CFG_PATTERN_LENGTH, len_data);
            write_reg(sfr_pkg::CFG_REPLACEMENT_BYTES, {$urandom, $urandom});
            case (ph)
                1:       len_nib = 4'd8;
                4:       len_nib = 4'd0;
                5:       len_nib = 4'd12;
                default: len_nib = 4'($urandom_range(1, 8));
            endcase
            len_data = {$urandom, $urandom};
            len_data[3:0] = len_nib;
            write_reg(sfr_pkg::CFG_REPLACEMENT_LENGTH, len_data);
            if (ph % 2 == 1)
                write_reg(INDEX_W'($urandom_range(4, 15)), {$urandom, $urandom});

            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                plen = eff_len(pat_len_reg);
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    // whole occurrence, now and then with one byte spoiled
                    spoil = ($urandom_range(0, 6) == 0) ? $urandom_range(0, plen - 1) : -1;
                    for (i = 0; i < plen; i++)
                    begin
                        b = (i == spoil) ? 8'($urandom_range(0, 255)) : pat_word[8*i +: 8];
                        send_byte(b, maybe_end(), USE_PREDICTION, 64'h0);
                        sent++;
                    end
                end
                else if (pick < 70)
                begin
                    cut = (plen > 1) ? $urandom_range(1, plen - 1) : 0;
                    for (i = 0; i < cut; i++)
                    begin
                        send_byte(pat_word[8*i +: 8], maybe_end(), USE_PREDICTION, 64'h0);
                        sent++;
                    end
                    send_byte(near_byte(plen), maybe_end(), USE_PREDICTION, 64'h0);
                    sent++;
                end
                else if (pick < 85)
                begin
                    send_byte(8'($urandom_range(0, 255)), maybe_end(), USE_PREDICTION, 64'h0);
                    sent++;
                end
                else if (pick < 92)
                begin
                    send_byte(sfr_pkg::NEWLINE_BYTE, maybe_end(), USE_PREDICTION, 64'h0);
                    sent++;
                end
                else
                begin
                    send_byte(near_byte(plen), maybe_end(), USE_PREDICTION, 64'h0);
                    sent++;
                end
            end
        end

        settle();
        if (failures == 0)
            $display("streaming_find_replace_tb OK");
        else
            $display("streaming_find_replace_tb NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/sfr_pkg.sv
rtl/sfr_match.sv
rtl/streaming_find_replace.sv
verif/streaming_find_replace_tb.sv
